// ===== hw/rtl/hmt_pkg.sv =====
// ----------------------------------------------------------------------------
// hmt_pkg
// Shared types and codes of the heartbeat membership table.
// ----------------------------------------------------------------------------
package hmt_pkg;

  localparam int HMT_TABLE_DEPTH = 32;
  localparam logic [15:0] HMT_TIMEOUT_RESET = 16'd5;

  // Input function codes
  localparam logic [1:0] FUNC_REPORT = 2'd0;
  localparam logic [1:0] FUNC_JOIN   = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // Commands after classification
  localparam logic [1:0] CMD_SELF   = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_JOIN   = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // Event kinds
  localparam logic [2:0] EV_SELF    = 3'd0;
  localparam logic [2:0] EV_ADDED   = 3'd1;
  localparam logic [2:0] EV_UPDATED = 3'd2;
  localparam logic [2:0] EV_STALE   = 3'd3;
  localparam logic [2:0] EV_FULL    = 3'd4;
  localparam logic [2:0] EV_DEAD    = 3'd5;
  localparam logic [2:0] EV_REMOVED = 3'd6;
  localparam logic [2:0] EV_SUMMARY = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] CFG_SELF_ID   = 2'd0;
  localparam logic [1:0] CFG_SELF_PORT = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
  } cmd_entry_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [31:0] seen;
  } entry_word_t;

  localparam int HMT_WORD_W = $bits(entry_word_t);

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [5:0]  alive;
    logic        last;
  } result_t;

endpackage

// ===== hw/rtl/hmt_ram.sv =====
// ----------------------------------------------------------------------------
// hmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/hmt_front.sv =====
// ----------------------------------------------------------------------------
// hmt_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module hmt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [31:0]        in_peer_id,
  input  logic [15:0]        in_peer_port,
  input  logic [31:0]        in_peer_heartbeat,
  input  logic [31:0]        self_id,
  input  logic [15:0]        self_port,
  input  logic               pop,
  output logic               q_vld,
  output hmt_pkg::cmd_entry_t q_head
);
  import hmt_pkg::*;

  cmd_entry_t slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_entry_t entry;

  assign busy  = (cnt_r == 2'd2);
  assign q_vld = (cnt_r != 2'd0);
  assign q_head = slot_r[rptr_r];
  assign push  = start && !busy && (in_func != FUNC_NONE);

  always_comb begin
    entry.id   = in_peer_id;
    entry.port = in_peer_port;
    entry.hb   = in_peer_heartbeat;
    case (in_func)
      FUNC_REPORT: entry.cmd = CMD_REPORT;
      FUNC_JOIN:   entry.cmd = CMD_JOIN;
      default:     entry.cmd = CMD_TICK;
    endcase
    if (in_func != FUNC_TICK && in_peer_id == self_id && in_peer_port == self_port) begin
      entry.cmd = CMD_SELF;
    end
  end

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = (pop && q_vld) ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop && q_vld};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= entry;
    end
  end

endmodule

// ===== hw/rtl/hmt_back.sv =====
// ----------------------------------------------------------------------------
// hmt_back
// Carries out queued commands: self-address reply, keyed lookup, insert/update and tick sweep.
// ----------------------------------------------------------------------------
module hmt_back #(
  parameter int DEPTH = hmt_pkg::HMT_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_vld,
  input  hmt_pkg::cmd_entry_t q_head,
  output logic                pop,
  input  logic [15:0]         timeout_ticks,
  output hmt_pkg::result_t    res
);
  import hmt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_APPLY = 3'd2;
  localparam logic [2:0] ST_COUNT = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;
  localparam logic [2:0] ST_SUM   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  cmd_entry_t       cmd_r, cmd_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             p_vld_r, p_vld_nxt;
  logic [AW-1:0]    p_idx_r, p_idx_nxt;
  logic             hit_r, hit_nxt;
  logic [AW-1:0]    hit_idx_r, hit_idx_nxt;
  entry_word_t      hit_word_r, hit_word_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [DEPTH-1:0] dead_r, dead_nxt;
  logic [5:0]       alive_r, alive_nxt;
  logic [5:0]       ndead_r, ndead_nxt;
  logic [31:0]      own_hb_r, own_hb_nxt;
  logic [31:0]      time_r, time_nxt;
  result_t          res_r, res_nxt;

  logic                  issue;
  logic                  we;
  logic [AW-1:0]         waddr;
  entry_word_t           wword;
  logic [HMT_WORD_W-1:0] rdata;
  entry_word_t           rd_word;
  logic                  pv;
  logic                  last_p;
  logic [31:0]           age;
  logic [31:0]           t1;
  logic [31:0]           t2;
  logic                  free_any;
  logic [AW-1:0]         free_idx;
  logic [5:0]            alive_fin;

  hmt_ram #(
    .WIDTH (HMT_WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wword),
    .re    (issue),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  assign rd_word   = entry_word_t'(rdata);
  assign pv        = valid_r[p_idx_r];
  assign last_p    = (p_idx_r == LAST_IDX);
  assign age       = time_r - rd_word.seen;
  assign t1        = {16'd0, timeout_ticks};
  assign t2        = {15'd0, timeout_ticks, 1'b0};
  assign alive_fin = alive_r - ndead_r;
  assign issue     = (state_r == ST_LOOK || state_r == ST_COUNT || state_r == ST_SWEEP)
                     && (idx_r < CW'(DEPTH));
  assign res       = res_r;

  // Lowest free slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    idx_nxt      = idx_r;
    p_vld_nxt    = 1'b0;
    p_idx_nxt    = p_idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_word_nxt = hit_word_r;
    valid_nxt    = valid_r;
    dead_nxt     = dead_r;
    alive_nxt    = alive_r;
    ndead_nxt    = ndead_r;
    own_hb_nxt   = own_hb_r;
    time_nxt     = time_r;
    pop          = 1'b0;
    we           = 1'b0;
    waddr        = hit_idx_r;
    wword.id     = cmd_r.id;
    wword.port   = cmd_r.port;
    wword.hb     = cmd_r.hb;
    wword.seen   = time_r;
    res_nxt       = '0;
    res_nxt.id    = cmd_r.id;
    res_nxt.port  = cmd_r.port;
    res_nxt.hb    = cmd_r.hb;
    res_nxt.alive = alive_r;

    // The table scan issues one read per cycle; each result comes back in the next cycle, registered by the RAM.
    if (issue) begin
      idx_nxt   = idx_r + CW'(1);
      p_vld_nxt = 1'b1;
      p_idx_nxt = idx_r[AW-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (q_vld) begin
          pop     = 1'b1;
          cmd_nxt = q_head;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          case (q_head.cmd)
            CMD_SELF: begin
              res_nxt.valid = 1'b1;
              res_nxt.kind  = EV_SELF;
              res_nxt.id    = q_head.id;
              res_nxt.port  = q_head.port;
              res_nxt.hb    = q_head.hb;
              res_nxt.last  = 1'b1;
            end
            CMD_TICK: begin
              if (own_hb_r != 32'hFFFF_FFFF) begin
                own_hb_nxt = own_hb_r + 32'd1;
              end
              ndead_nxt = '0;
              state_nxt = ST_COUNT;
            end
            default: state_nxt = ST_LOOK;
          endcase
        end
      end
      ST_LOOK: begin
        if (p_vld_r) begin
          if (pv && rd_word.id == cmd_r.id && rd_word.port == cmd_r.port) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = p_idx_r;
            hit_word_nxt = rd_word;
            state_nxt    = ST_APPLY;
          end else if (last_p) begin
            state_nxt = ST_APPLY;
          end
        end
      end
      ST_APPLY: begin
        state_nxt     = ST_IDLE;
        res_nxt.valid = 1'b1;
        res_nxt.last  = 1'b1;
        if (hit_r) begin
          if (cmd_r.cmd == CMD_REPORT && cmd_r.hb > hit_word_r.hb) begin
            we           = 1'b1;
            res_nxt.kind = EV_UPDATED;
          end else begin
            res_nxt.kind = EV_STALE;
            res_nxt.hb   = hit_word_r.hb;
          end
        end else if (free_any) begin
          we                  = 1'b1;
          waddr               = free_idx;
          valid_nxt[free_idx] = 1'b1;
          dead_nxt[free_idx]  = 1'b0;
          alive_nxt           = alive_r + 6'd1;
          res_nxt.kind        = EV_ADDED;
          res_nxt.alive       = alive_r + 6'd1;
        end else begin
          res_nxt.kind = EV_FULL;
        end
      end
      ST_COUNT: begin
        // First pass only counts the entries that will time out, so that every
        // result of the tick can carry the final alive count.
        if (p_vld_r) begin
          if (pv && !dead_r[p_idx_r] && age > t1) begin
            ndead_nxt = ndead_r + 6'd1;
          end
          if (last_p) begin
            state_nxt = ST_SWEEP;
            idx_nxt   = '0;
            p_vld_nxt = 1'b0;
          end
        end
      end
      ST_SWEEP: begin
        res_nxt.id    = rd_word.id;
        res_nxt.port  = rd_word.port;
        res_nxt.hb    = rd_word.hb;
        res_nxt.alive = alive_fin;
        if (p_vld_r) begin
          if (pv) begin
            if (!dead_r[p_idx_r]) begin
              if (age > t1) begin
                dead_nxt[p_idx_r] = 1'b1;
                res_nxt.valid     = 1'b1;
                res_nxt.kind      = EV_DEAD;
              end
            end else if (age > t2) begin
              valid_nxt[p_idx_r] = 1'b0;
              res_nxt.valid      = 1'b1;
              res_nxt.kind       = EV_REMOVED;
            end
          end
          if (last_p) begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        res_nxt.valid = 1'b1;
        res_nxt.kind  = EV_SUMMARY;
        res_nxt.id    = '0;
        res_nxt.port  = '0;
        res_nxt.hb    = own_hb_r;
        res_nxt.alive = alive_fin;
        res_nxt.last  = 1'b1;
        alive_nxt     = alive_fin;
        if (time_r != 32'hFFFF_FFFF) begin
          time_nxt = time_r + 32'd1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      p_vld_r  <= 1'b0;
      valid_r  <= '0;
      dead_r   <= '0;
      alive_r  <= '0;
      ndead_r  <= '0;
      own_hb_r <= '0;
      time_r   <= '0;
      res_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      p_vld_r  <= p_vld_nxt;
      valid_r  <= valid_nxt;
      dead_r   <= dead_nxt;
      alive_r  <= alive_nxt;
      ndead_r  <= ndead_nxt;
      own_hb_r <= own_hb_nxt;
      time_r   <= time_nxt;
      res_r    <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    p_idx_r    <= p_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_word_r <= hit_word_nxt;
  end

`ifndef SYNTHESIS
  a_alive_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (alive_r == 6'($countones(valid_r & ~dead_r))))
    else $error("alive count out of step with the table");
  a_sweep_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.valid && (res_r.kind == EV_DEAD || res_r.kind == EV_REMOVED)) |-> !res_r.last)
    else $error("sweep event flagged as last");
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.valid && res_r.kind != EV_DEAD && res_r.kind != EV_REMOVED) |-> res_r.last)
    else $error("closing event without last flag");
  a_ndead_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP || state_r == ST_SUM) |-> (ndead_r <= alive_r))
    else $error("more timeouts than alive entries");
`endif

endmodule

// ===== hw/rtl/heartbeat_membership_table_core.sv =====
// ----------------------------------------------------------------------------
// heartbeat_membership_table_core
// Peer membership table with heartbeat updates and timeout sweeps.
//
//   Channel | Handshake              | Ports
//   --------+------------------------+-------------------------------------
//   input   | start && !busy         | in_func, in_peer_*
//   result  | out_valid, one cycle   | out_event_kind .. out_last
//   config  | cfg_valid && cfg_ready | cfg_index, cfg_data
//
// Each accepted item is carried out in turn: a self-address item is answered from
// the queue head without a table scan; a report or join scans the table through
// the RAM, one entry per cycle, stopping at a hit, and then applies; a tick makes
// two RAM passes (count, then sweep) and closes with the summary. Two queued
// items may wait while one is being carried out; busy rises when the queue is
// full. Reset is synchronous and empties the table at once. Results cannot be
// stalled by the receiver.
// ----------------------------------------------------------------------------
module heartbeat_membership_table_core #(
  parameter int TABLE_DEPTH = hmt_pkg::HMT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_peer_id,
  input  logic [15:0] in_peer_port,
  input  logic [31:0] in_peer_heartbeat,
  output logic        out_valid,
  output logic [2:0]  out_event_kind,
  output logic [31:0] out_id,
  output logic [15:0] out_port,
  output logic [31:0] out_heartbeat,
  output logic [5:0]  out_alive_count,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import hmt_pkg::*;

  logic [31:0] self_id_r;
  logic [15:0] self_port_r;
  logic [15:0] timeout_r;
  logic        q_vld;
  logic        pop;
  cmd_entry_t  q_head;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r   <= '0;
      self_port_r <= '0;
      timeout_r   <= HMT_TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SELF_ID:   self_id_r   <= cfg_data;
        CFG_SELF_PORT: self_port_r <= cfg_data[15:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  hmt_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_peer_id        (in_peer_id),
    .in_peer_port      (in_peer_port),
    .in_peer_heartbeat (in_peer_heartbeat),
    .self_id           (self_id_r),
    .self_port         (self_port_r),
    .pop               (pop),
    .q_vld             (q_vld),
    .q_head            (q_head)
  );

  hmt_back #(
    .DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_vld         (q_vld),
    .q_head        (q_head),
    .pop           (pop),
    .timeout_ticks (timeout_r),
    .res           (res)
  );

  assign out_valid       = res.valid;
  assign out_event_kind  = res.kind;
  assign out_id          = res.id;
  assign out_port        = res.port;
  assign out_heartbeat   = res.hb;
  assign out_alive_count = res.alive;
  assign out_last        = res.last;

endmodule

// ===== test/tb_heartbeat_membership_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_heartbeat_membership_table_core
// Self-checking bench for the heartbeat membership table. A behavioral table
// model predicts the events of every accepted report, join and tick, and a
// scoreboard checks each strobed result in order.
// ----------------------------------------------------------------------------
module tb_heartbeat_membership_table_core;
  import hmt_pkg::*;

  localparam int DEPTH = HMT_TABLE_DEPTH;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [5:0]  alive;
    logic        last;
  } event_t;

  class event_scoreboard;
    event_t pending[$];
    int     mismatches;
    int     checked;

    // Predictor state.
    logic [31:0] my_id;
    logic [15:0] my_port;
    logic [15:0] timeout;
    bit          valid_q[DEPTH];
    bit          dead_q[DEPTH];
    logic [31:0] id_q[DEPTH];
    logic [15:0] port_q[DEPTH];
    logic [31:0] hb_q[DEPTH];
    logic [31:0] seen_q[DEPTH];
    logic [31:0] own_hb;
    logic [31:0] now;

    function new();
      my_id = 0; my_port = 0; timeout = HMT_TIMEOUT_RESET;
      own_hb = 0; now = 0; mismatches = 0; checked = 0;
      foreach (valid_q[i]) valid_q[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_SELF_ID:   my_id = data;
        CFG_SELF_PORT: my_port = data[15:0];
        CFG_TIMEOUT:   timeout = data[15:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [1:0] func, logic [31:0] id, logic [15:0] port,
                             logic [31:0] hb);
      event_t evs[$];
      event_t e;
      int slot;
      int free_slot;
      logic [31:0] age;
      logic [5:0] alive;
      if (func == FUNC_NONE) return;
      if (func == FUNC_TICK) begin
        if (own_hb != 32'hFFFFFFFF) own_hb++;
        for (int i = 0; i < DEPTH; i++) begin
          if (!valid_q[i]) continue;
          age = now - seen_q[i];
          e = '{kind: EV_DEAD, id: id_q[i], port: port_q[i], hb: hb_q[i],
                alive: 0, last: 0};
          if (!dead_q[i]) begin
            if ({32'd0, age} > {48'd0, timeout}) begin
              dead_q[i] = 1;
              evs.push_back(e);
            end
          end else if ({32'd0, age} > {47'd0, timeout, 1'b0}) begin
            valid_q[i] = 0;
            e.kind = EV_REMOVED;
            evs.push_back(e);
          end
        end
        evs.push_back('{kind: EV_SUMMARY, id: 0, port: 0, hb: own_hb, alive: 0, last: 0});
        if (now != 32'hFFFFFFFF) now++;
      end else if (id == my_id && port == my_port) begin
        evs.push_back('{kind: EV_SELF, id: id, port: port, hb: hb, alive: 0, last: 0});
      end else begin
        slot = -1;
        free_slot = -1;
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (valid_q[i] && id_q[i] == id && port_q[i] == port) slot = i;
          if (!valid_q[i]) free_slot = i;
        end
        e = '{kind: EV_ADDED, id: id, port: port, hb: hb, alive: 0, last: 0};
        if (slot >= 0) begin
          if (func == FUNC_REPORT && hb > hb_q[slot]) begin
            hb_q[slot] = hb;
            seen_q[slot] = now;
            e.kind = EV_UPDATED;
          end else begin
            e.kind = EV_STALE;
            e.hb = hb_q[slot];
          end
        end else if (free_slot >= 0) begin
          valid_q[free_slot] = 1;
          dead_q[free_slot] = 0;
          id_q[free_slot] = id;
          port_q[free_slot] = port;
          hb_q[free_slot] = hb;
          seen_q[free_slot] = now;
        end else begin
          e.kind = EV_FULL;
        end
        evs.push_back(e);
      end
      alive = 0;
      for (int i = 0; i < DEPTH; i++) if (valid_q[i] && !dead_q[i]) alive++;
      foreach (evs[k]) begin
        evs[k].alive = alive;
        evs[k].last = (k == evs.size() - 1);
        pending.push_back(evs[k]);
      end
    endfunction

    function void check_result(event_t got);
      event_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction

    function int count_alive_entries();
      int n = 0;
      for (int i = 0; i < DEPTH; i++) if (valid_q[i] && !dead_q[i]) n++;
      return n;
    endfunction

    function int count_entries();
      int n = 0;
      for (int i = 0; i < DEPTH; i++) if (valid_q[i]) n++;
      return n;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [31:0] in_peer_id;
  logic [15:0] in_peer_port;
  logic [31:0] in_peer_heartbeat;
  logic        out_valid;
  logic [2:0]  out_event_kind;
  logic [31:0] out_id;
  logic [15:0] out_port;
  logic [31:0] out_heartbeat;
  logic [5:0]  out_alive_count;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  event_scoreboard sb;
  int cycles;
  int sent;
  int ticks_sent;
  int burst_left;
  logic [31:0] pool_id[8];
  logic [15:0] pool_port[8];

  heartbeat_membership_table_core dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Results cannot be held off, so every strobe is checked at the edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid)
      sb.check_result('{kind: out_event_kind, id: out_id, port: out_port,
                        hb: out_heartbeat, alive: out_alive_count, last: out_last});
    if (cycles > CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] func, logic [31:0] id, logic [15:0] port,
                           logic [31:0] hb);
    int gap;
    // Sender idles for random gaps between bursts so gaps land on varied phases of the sweep.
    if (burst_left == 0) begin
      gap = $urandom_range(0, 40);
      if (gap > 0) begin
        start <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1;
    in_func <= func;
    in_peer_id <= id;
    in_peer_port <= port;
    in_peer_heartbeat <= hb;
    do @(posedge clk); while (busy);
    sb.note_input(func, id, port, hb);
    sent++;
    if (func == FUNC_TICK) ticks_sent++;
  endtask

  task automatic wait_idle();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(int n, int tick_pct);
    logic [1:0] func;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      func = (r < tick_pct) ? FUNC_TICK : (r < tick_pct + 12) ? FUNC_JOIN :
             (r < tick_pct + 15) ? FUNC_NONE : FUNC_REPORT;
      id = $urandom();
      port = 16'($urandom());
      // Most reports name a small pool of peers so entries age and update.
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 7);
        id = pool_id[r];
        port = pool_port[r];
      end else if ($urandom_range(0, 19) == 0) begin
        id = sb.my_id;
        port = sb.my_port;
      end
      hb = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 40);
      send_item(func, id, port, hb);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0; sent = 0; ticks_sent = 0; burst_left = 0;
    rst_n = 0; start = 0; in_func = FUNC_NONE;
    in_peer_id = 0; in_peer_port = 0; in_peer_heartbeat = 0;
    cfg_valid = 0; cfg_index = CFG_SELF_ID; cfg_data = 0;
    foreach (pool_id[i]) begin
      pool_id[i] = $urandom();
      pool_port[i] = 16'($urandom());
    end
    pool_id[0] = 32'hFFFFFFFF; pool_port[0] = 16'hFFFF;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: self at reset address, extremes, stale, join, dead, removal.
    send_item(FUNC_REPORT, 32'd0, 16'd0, 32'hFFFFFFFF);
    wait_idle();
    write_reg(CFG_SELF_ID, 32'hA5A5_0001);
    write_reg(CFG_SELF_PORT, 32'h1234);
    write_reg(CFG_TIMEOUT, 32'd1);
    send_item(FUNC_REPORT, 32'hA5A5_0001, 16'h1234, 32'd7);
    send_item(FUNC_JOIN, 32'hA5A5_0001, 16'h1234, 32'd7);
    send_item(FUNC_REPORT, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_item(FUNC_REPORT, 32'd0, 16'd0, 32'd0);
    send_item(FUNC_REPORT, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_item(FUNC_REPORT, 32'd0, 16'd0, 32'd5);
    send_item(FUNC_JOIN, 32'd0, 16'd0, 32'd9);
    send_item(FUNC_JOIN, 32'h5555_AAAA, 16'hAA55, 32'd3);
    send_item(FUNC_NONE, 32'h1, 16'h1, 32'd1);
    repeat (3) send_item(FUNC_TICK, $urandom(), 16'($urandom()), $urandom());
    send_item(FUNC_REPORT, 32'd0, 16'd0, 32'd6);
    repeat (3) send_item(FUNC_TICK, 32'd0, 16'd0, 32'd0);
    wait_idle();

    // Zero timeout, then fill the table past its depth.
    write_reg(CFG_TIMEOUT, 32'd0);
    for (int i = 0; i < DEPTH + 2; i++) send_item(FUNC_JOIN, 32'h100 + i, 16'(i), i);
    repeat (4) send_item(FUNC_TICK, 32'd0, 16'd0, 32'd0);
    wait_idle();

    write_reg(CFG_TIMEOUT, 32'hFFFF);
    write_reg(CFG_SELF_ID, 32'hFFFFFFFF);
    write_reg(CFG_SELF_PORT, 32'hFFFF);
    random_phase(110, 10);
    wait_idle();

    write_reg(CFG_TIMEOUT, 32'd3);
    write_reg(CFG_SELF_ID, 32'd0);
    write_reg(CFG_SELF_PORT, 32'd0);
    random_phase(160, 25);
    wait_idle();

    write_reg(CFG_TIMEOUT, 32'd2);
    write_reg(CFG_SELF_ID, pool_id[3]);
    write_reg(CFG_SELF_PORT, {16'd0, pool_port[3]});
    random_phase(120, 30);
    wait_idle();

    $display("Sent %0d items (%0d ticks), checked %0d results; %0d entries (%0d alive) at end.",
             sent, ticks_sent, sb.checked, sb.count_entries(), sb.count_alive_entries());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/hmt_pkg.sv
hw/rtl/hmt_ram.sv
hw/rtl/hmt_front.sv
hw/rtl/hmt_back.sv
hw/rtl/heartbeat_membership_table_core.sv
test/tb_heartbeat_membership_table_core.sv
